// ----- design/evsb_pkg.sv -----
// ----------------------------------------------------------------------------
// evsb_pkg
// shared types, codes and fixed-point constants of the velocity source blender
// ----------------------------------------------------------------------------
package evsb_pkg;

  localparam int unsigned MAX_SOURCES_DEF = 16;

  // request action codes
  localparam logic [1:0] ACT_REFRESH = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;
  localparam logic [1:0] ACT_TICK    = 2'd3;

  // q1.30 arithmetic
  localparam int unsigned QW        = 31;
  localparam logic [QW-1:0] Q30_ONE  = 31'd1073741824;
  localparam logic [QW-1:0] Q30_HALF = 31'd536870912;
  localparam logic [63:0] EXP_BASE   = 64'd1073725440;
  localparam int unsigned EXP_BITS   = 21;
  localparam logic [64:0] CUTOFF_SQ  = 65'd10737418;

  // ratio divider: (tick << 16) / response
  localparam int unsigned DIVD_W = 48;
  localparam int unsigned DIVS_W = 32;

  typedef logic [QW-1:0] exp_tab_t [EXP_BITS];

  // exp(-2^(i-16)) in q1.30, each factor the rounded square of the one before
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    t;
    logic [63:0] e;
    e = EXP_BASE;
    for (int i = 0; i < EXP_BITS; i++) begin
      t[i] = e[QW-1:0];
      e    = (e * e + 64'(Q30_HALF)) >> 30;
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

  typedef struct packed {
    logic [63:0]        key;
    logic signed [31:0] tgt_x;
    logic signed [31:0] tgt_y;
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic [31:0]        resp;
    logic [31:0]        remain;
  } slot_rec_t;

endpackage

// ----- design/evsb_if.sv -----
// ----------------------------------------------------------------------------
// evsb_if
// request and result channels of the velocity source blender
// ----------------------------------------------------------------------------
interface evsb_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [63:0]        src_key;
  logic signed [31:0] target_vx;
  logic signed [31:0] target_vy;
  logic [31:0]        response_us;
  logic [31:0]        expiry_us;
  logic [31:0]        tick_us;

  modport source (output valid, action, src_key, target_vx, target_vy, response_us,
                  expiry_us, tick_us, input ready);
  modport sink (input valid, action, src_key, target_vx, target_vy, response_us,
                expiry_us, tick_us, output ready);
endinterface

interface evsb_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] combined_vx;
  logic signed [31:0] combined_vy;
  logic               accepted;
  logic [4:0]         active_count;

  modport source (output valid, combined_vx, combined_vy, accepted, active_count,
                  input ready);
  modport sink (input valid, combined_vx, combined_vy, accepted, active_count,
                output ready);
endinterface

// ----- design/expiring_velocity_source_blender.sv -----
// ----------------------------------------------------------------------------
// expiring_velocity_source_blender
// table of expiring velocity sources, blended and summed on each tick
// ----------------------------------------------------------------------------
// usage
//   req_i carries one request: refresh, release, clear or tick. rsp_o returns
//   exactly one result per request: the sums latched by the last tick or clear, an
//   accepted flag and the number of held sources
//   slot records live in one synchronous memory; a sequencer reads one slot,
//   works on it and writes it back, so only one access is ever in flight
//   clear empties the table without a scan; refresh and release scan the keys
//   slot by slot; a tick steps past each empty slot and, for a held slot, reads
//   and loads it, runs the ratio divider and the exponential product, then
//   blends, squares and writes back (the divide and the product are skipped
//   when no divide is needed), and then finishes
//   req_i.ready is high while the sequencer is idle, also while a result
//   waits; a stalled rsp_o holds the finished request in its last state
//   reset empties the table and zeroes the sums; no clearing pass is needed
//   since the valid bits sit in flops
// ----------------------------------------------------------------------------
module expiring_velocity_source_blender #(
  parameter int unsigned MAX_SOURCES = evsb_pkg::MAX_SOURCES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  evsb_req_if.sink    req_i,
  evsb_rsp_if.source  rsp_o
);

  localparam int unsigned IdxW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int unsigned CntW = $clog2(MAX_SOURCES + 1);
  localparam int unsigned SumW = 32 + CntW + 1;
  localparam logic signed [SumW-1:0] SatHi = SumW'(64'sd2147483647);
  localparam logic signed [SumW-1:0] SatLo = SumW'(-64'sd2147483648);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LK_RD  = 4'd1;
  localparam logic [3:0] S_LK_CMP = 4'd2;
  localparam logic [3:0] S_LK_DEC = 4'd3;
  localparam logic [3:0] S_LK_WR  = 4'd4;
  localparam logic [3:0] S_TK_RD  = 4'd5;
  localparam logic [3:0] S_TK_LD  = 4'd6;
  localparam logic [3:0] S_TK_DIV = 4'd7;
  localparam logic [3:0] S_TK_EXP = 4'd8;
  localparam logic [3:0] S_TK_MX  = 4'd9;
  localparam logic [3:0] S_TK_MY  = 4'd10;
  localparam logic [3:0] S_TK_SQX = 4'd11;
  localparam logic [3:0] S_TK_SQY = 4'd12;
  localparam logic [3:0] S_TK_WR  = 4'd13;
  localparam logic [3:0] S_FIN    = 4'd14;

  logic [3:0]             state_q;
  logic [MAX_SOURCES-1:0] valid_q;
  logic [CntW-1:0]        cnt_q;
  logic [IdxW:0]          idx_q;
  logic [IdxW-1:0]        slot_q;
  logic [IdxW-1:0]        free_q;
  logic                   free_found_q;
  logic                   new_q;
  logic                   acc_q;
  logic signed [31:0]     sum_x_q;
  logic signed [31:0]     sum_y_q;
  logic signed [SumW-1:0] ax_q;
  logic signed [SumW-1:0] ay_q;
  logic                   out_valid_q;
  logic                   out_valid_d;

  // latched request and per-slot working registers
  logic [1:0]                act_q;
  logic [63:0]               id_q;
  logic signed [31:0]        tx_q;
  logic signed [31:0]        ty_q;
  logic [31:0]               resp_q;
  logic [31:0]               exp_q;
  logic [31:0]               dt_q;
  evsb_pkg::slot_rec_t       rec_q;
  logic                      expired_q;
  logic [evsb_pkg::QW-1:0]   blend_q;
  logic [evsb_pkg::QW-1:0]   p_q;
  logic [evsb_pkg::EXP_BITS-1:0] x_q;
  logic [4:0]                k_q;
  logic [63:0]               sqx_q;
  logic                      drop_q;
  logic signed [31:0]        out_vx_q;
  logic signed [31:0]        out_vy_q;
  logic                      out_acc_q;
  logic [4:0]                out_cnt_q;

  // memory ports
  logic                mem_we;
  logic [IdxW-1:0]     mem_waddr;
  evsb_pkg::slot_rec_t mem_wdata;
  logic                mem_re;
  evsb_pkg::slot_rec_t mem_rd;

  // divider
  logic                        div_start;
  logic                        div_done;
  logic [evsb_pkg::DIVD_W-1:0] div_quo;

  logic req_fire;
  logic fin_go;
  logic idx_end;
  logic cur_valid;

  assign req_fire  = req_i.valid && req_i.ready;
  assign fin_go    = !out_valid_q || rsp_o.ready;
  assign idx_end   = idx_q == (IdxW + 1)'(MAX_SOURCES);
  assign cur_valid = !idx_end && valid_q[idx_q[IdxW-1:0]];

  // result register holds until taken, reloads when a request finishes
  assign out_valid_d = ((state_q == S_FIN) && fin_go) || (out_valid_q && !rsp_o.ready);

  // tick slot load: countdown and expiry of the target
  logic [31:0]         rem_new;
  logic                exp_new;
  evsb_pkg::slot_rec_t ld_rec;
  assign rem_new = (mem_rd.remain > dt_q) ? (mem_rd.remain - dt_q) : 32'd0;
  assign exp_new = rem_new == 32'd0;

  always_comb begin
    ld_rec        = mem_rd;
    ld_rec.remain = rem_new;
    if (exp_new) begin
      ld_rec.tgt_x = '0;
      ld_rec.tgt_y = '0;
    end
  end

  assign div_start = (state_q == S_TK_LD) && (mem_rd.resp > 32'd1) && (dt_q != 32'd0);

  // exponential product step
  logic [61:0]             exp_prod;
  logic [61:0]             exp_rnd;
  logic [evsb_pkg::QW-1:0] p_next;
  assign exp_prod = 62'(p_q) * 62'(evsb_pkg::EXP_TAB[k_q]);
  assign exp_rnd  = (exp_prod + 62'(evsb_pkg::Q30_HALF)) >> 30;
  assign p_next   = x_q[k_q] ? exp_rnd[evsb_pkg::QW-1:0] : p_q;

  // shared blend step: current moves toward target, ties rounded away from zero
  logic signed [31:0] ap_cur;
  logic signed [31:0] ap_tgt;
  logic signed [32:0] ap_diff;
  logic [32:0]        ap_mag;
  logic [63:0]        ap_prod;
  logic [63:0]        ap_rnd;
  logic [33:0]        ap_res;
  logic signed [31:0] ap_new;

  assign ap_cur  = (state_q == S_TK_MX) ? rec_q.cur_x : rec_q.cur_y;
  assign ap_tgt  = (state_q == S_TK_MX) ? rec_q.tgt_x : rec_q.tgt_y;
  assign ap_diff = 33'(ap_tgt) - 33'(ap_cur);
  assign ap_mag  = ap_diff[32] ? 33'(-ap_diff) : 33'(ap_diff);
  assign ap_prod = 64'(ap_mag) * 64'(blend_q);
  assign ap_rnd  = (ap_prod + 64'(evsb_pkg::Q30_HALF)) >> 30;
  assign ap_res  = ap_diff[32] ? (34'(ap_cur) - 34'(ap_rnd[32:0]))
                               : (34'(ap_cur) + 34'(ap_rnd[32:0]));
  assign ap_new  = ap_res[31:0];

  // shared square for the cutoff test
  logic signed [31:0] sq_in;
  logic [31:0]        sq_mag;
  logic [63:0]        sq_val;
  logic               below_cut;
  assign sq_in     = (state_q == S_TK_SQX) ? rec_q.cur_x : rec_q.cur_y;
  assign sq_mag    = sq_in[31] ? 32'(-sq_in) : 32'(sq_in);
  assign sq_val    = 64'(sq_mag) * 64'(sq_mag);
  assign below_cut = (65'(sqx_q) + 65'(sq_val)) <= evsb_pkg::CUTOFF_SQ;

  // saturated sums at the end of a tick
  logic signed [31:0] sat_x;
  logic signed [31:0] sat_y;
  always_comb begin
    if (ax_q > SatHi) begin
      sat_x = 32'sh7fffffff;
    end else if (ax_q < SatLo) begin
      sat_x = 32'sh80000000;
    end else begin
      sat_x = ax_q[31:0];
    end
    if (ay_q > SatHi) begin
      sat_y = 32'sh7fffffff;
    end else if (ay_q < SatLo) begin
      sat_y = 32'sh80000000;
    end else begin
      sat_y = ay_q[31:0];
    end
  end

  // memory access
  always_comb begin
    mem_re    = ((state_q == S_LK_RD) || (state_q == S_TK_RD)) && cur_valid;
    mem_we    = (state_q == S_LK_WR) || (state_q == S_TK_WR);
    mem_waddr = (state_q == S_LK_WR) ? slot_q : idx_q[IdxW-1:0];
    mem_wdata = rec_q;
    if (state_q == S_LK_WR) begin
      if (act_q == evsb_pkg::ACT_REFRESH) begin
        mem_wdata.key    = id_q;
        mem_wdata.tgt_x  = tx_q;
        mem_wdata.tgt_y  = ty_q;
        mem_wdata.resp   = resp_q;
        mem_wdata.remain = exp_q;
        if (new_q) begin
          mem_wdata.cur_x = '0;
          mem_wdata.cur_y = '0;
        end
      end else begin
        mem_wdata.tgt_x  = '0;
        mem_wdata.tgt_y  = '0;
        mem_wdata.remain = '0;
      end
    end
  end

  evsb_slot_mem #(
    .DEPTH (MAX_SOURCES),
    .AW    (IdxW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_en_i   (mem_re),
    .rd_addr_i (idx_q[IdxW-1:0]),
    .rd_data_o (mem_rd)
  );

  evsb_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({dt_q, 16'd0}),
    .divisor_i  (mem_rd.resp),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      valid_q      <= '0;
      cnt_q        <= '0;
      idx_q        <= '0;
      slot_q       <= '0;
      free_q       <= '0;
      free_found_q <= 1'b0;
      new_q        <= 1'b0;
      acc_q        <= 1'b0;
      sum_x_q      <= '0;
      sum_y_q      <= '0;
      ax_q         <= '0;
      ay_q         <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            idx_q        <= '0;
            free_found_q <= 1'b0;
            ax_q         <= '0;
            ay_q         <= '0;
            if (req_i.action == evsb_pkg::ACT_CLEAR) begin
              acc_q   <= 1'b1;
              valid_q <= '0;
              cnt_q   <= '0;
              sum_x_q <= '0;
              sum_y_q <= '0;
              state_q <= S_FIN;
            end else if (req_i.action == evsb_pkg::ACT_TICK) begin
              acc_q   <= 1'b1;
              state_q <= S_TK_RD;
            end else if (req_i.src_key == 64'd0) begin
              acc_q   <= 1'b0;
              state_q <= S_FIN;
            end else begin
              acc_q   <= 1'b1;
              state_q <= S_LK_RD;
            end
          end
        end
        S_LK_RD: begin
          if (idx_end) begin
            state_q <= S_LK_DEC;
          end else if (cur_valid) begin
            state_q <= S_LK_CMP;
          end else begin
            // lowest free slot for an insert
            if (!free_found_q) begin
              free_q       <= idx_q[IdxW-1:0];
              free_found_q <= 1'b1;
            end
            idx_q <= idx_q + 1'b1;
          end
        end
        S_LK_CMP: begin
          if (mem_rd.key == id_q) begin
            slot_q  <= idx_q[IdxW-1:0];
            new_q   <= 1'b0;
            state_q <= S_LK_WR;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_LK_RD;
          end
        end
        S_LK_DEC: begin
          // key not held: insert on refresh if room, else refuse
          if ((act_q == evsb_pkg::ACT_REFRESH) && free_found_q) begin
            slot_q  <= free_q;
            new_q   <= 1'b1;
            state_q <= S_LK_WR;
          end else begin
            acc_q   <= 1'b0;
            state_q <= S_FIN;
          end
        end
        S_LK_WR: begin
          if (new_q) begin
            valid_q[slot_q] <= 1'b1;
            cnt_q           <= cnt_q + 1'b1;
          end
          state_q <= S_FIN;
        end
        S_TK_RD: begin
          if (idx_end) begin
            sum_x_q <= sat_x;
            sum_y_q <= sat_y;
            state_q <= S_FIN;
          end else if (cur_valid) begin
            state_q <= S_TK_LD;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_TK_LD: begin
          state_q <= div_start ? S_TK_DIV : S_TK_MX;
        end
        S_TK_DIV: begin
          if (div_done) begin
            state_q <= (div_quo[evsb_pkg::DIVD_W-1:evsb_pkg::EXP_BITS] != '0) ? S_TK_MX
                                                                                : S_TK_EXP;
          end
        end
        S_TK_EXP: begin
          if (k_q == 5'(evsb_pkg::EXP_BITS - 1)) begin
            state_q <= S_TK_MX;
          end
        end
        S_TK_MX:  state_q <= S_TK_MY;
        S_TK_MY:  state_q <= S_TK_SQX;
        S_TK_SQX: state_q <= S_TK_SQY;
        S_TK_SQY: state_q <= S_TK_WR;
        S_TK_WR: begin
          if (drop_q) begin
            valid_q[idx_q[IdxW-1:0]] <= 1'b0;
            cnt_q                    <= cnt_q - 1'b1;
          end else begin
            ax_q <= ax_q + SumW'(rec_q.cur_x);
            ay_q <= ay_q + SumW'(rec_q.cur_y);
          end
          idx_q   <= idx_q + 1'b1;
          state_q <= S_TK_RD;
        end
        S_FIN: begin
          if (fin_go) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          act_q  <= req_i.action;
          id_q   <= req_i.src_key;
          tx_q   <= req_i.target_vx;
          ty_q   <= req_i.target_vy;
          resp_q <= req_i.response_us;
          exp_q  <= req_i.expiry_us;
          dt_q   <= req_i.tick_us;
        end
      end
      S_LK_CMP: begin
        rec_q <= mem_rd;
      end
      S_TK_LD: begin
        rec_q     <= ld_rec;
        expired_q <= exp_new;
        // short response jumps, zero tick holds
        blend_q <= (mem_rd.resp <= 32'd1) ? evsb_pkg::Q30_ONE : '0;
      end
      S_TK_DIV: begin
        if (div_done) begin
          blend_q <= evsb_pkg::Q30_ONE;
          p_q     <= evsb_pkg::Q30_ONE;
          x_q     <= div_quo[evsb_pkg::EXP_BITS-1:0];
          k_q     <= '0;
        end
      end
      S_TK_EXP: begin
        p_q     <= p_next;
        k_q     <= k_q + 1'b1;
        blend_q <= evsb_pkg::Q30_ONE - p_next;
      end
      S_TK_MX:  rec_q.cur_x <= ap_new;
      S_TK_MY:  rec_q.cur_y <= ap_new;
      S_TK_SQX: sqx_q <= sq_val;
      S_TK_SQY: drop_q <= expired_q && below_cut;
      S_FIN: begin
        if (fin_go) begin
          out_vx_q  <= sum_x_q;
          out_vy_q  <= sum_y_q;
          out_acc_q <= acc_q;
          out_cnt_q <= (32'(cnt_q) > 32'd31) ? 5'd31 : 5'(cnt_q);
        end
      end
      default: ;
    endcase
  end

  assign req_i.ready        = state_q == S_IDLE;
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.combined_vx  = out_vx_q;
  assign rsp_o.combined_vy  = out_vy_q;
  assign rsp_o.accepted     = out_acc_q;
  assign rsp_o.active_count = out_cnt_q;

endmodule

// ----- design/evsb_slot_mem.sv -----
// ----------------------------------------------------------------------------
// evsb_slot_mem
// slot record memory, one write and one read port, registered read data
// ----------------------------------------------------------------------------
module evsb_slot_mem #(
  parameter int unsigned DEPTH = evsb_pkg::MAX_SOURCES_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  evsb_pkg::slot_rec_t wr_data_i,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       rd_addr_i,
  output evsb_pkg::slot_rec_t rd_data_o
);

  evsb_pkg::slot_rec_t mem [DEPTH];
  evsb_pkg::slot_rec_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ----- design/evsb_divider.sv -----
// ----------------------------------------------------------------------------
// evsb_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module evsb_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [evsb_pkg::DIVD_W-1:0] dividend_i,
  input  logic [evsb_pkg::DIVS_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [evsb_pkg::DIVD_W-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(evsb_pkg::DIVD_W + 1);

  logic                        busy_q;
  logic [CW-1:0]               cnt_q;
  logic [evsb_pkg::DIVS_W:0]   rem_q;
  logic [evsb_pkg::DIVD_W-1:0] quo_q;
  logic [evsb_pkg::DIVS_W-1:0] dvs_q;
  logic                        done_q;
  logic [evsb_pkg::DIVS_W:0]   trial;
  logic                        take;

  assign trial = {rem_q[evsb_pkg::DIVS_W-1:0], quo_q[evsb_pkg::DIVD_W-1]};
  assign take  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(evsb_pkg::DIVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= take ? (trial - {1'b0, dvs_q}) : trial;
      quo_q <= {quo_q[evsb_pkg::DIVD_W-2:0], take};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
